@@ design/msplit_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msplit_pkg: shared types and constants of the message splitter
// Widths, configuration register indices, reset values, header step codes,
// controller states and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package msplit_pkg;

  localparam int LEN_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W     = 3;
  localparam int DIV_CNT_W  = $clog2(LEN_W + 1);

  // Bytes of a split chunk header.
  localparam int HDR_BYTES = 7;

  // Configuration register indices.
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGINAL_TYPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_TYPE    = 2'd2;

  // Register values after reset.
  localparam logic [LEN_W-1:0]  RST_CHUNK_LIMIT   = 16'd1024;
  localparam logic [BYTE_W-1:0] RST_ORIGINAL_TYPE = 8'd1;
  localparam logic [BYTE_W-1:0] RST_SPLIT_TYPE    = 8'd2;

  // Output steps for one input byte. The unsplit packet's type byte uses the
  // slot just before the payload byte, as does the low chunk index byte.
  localparam logic [STEP_W-1:0] STEP_TYPE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SEQ_HI = 3'd1;
  localparam logic [STEP_W-1:0] STEP_SEQ_LO = 3'd2;
  localparam logic [STEP_W-1:0] STEP_TOT_HI = 3'd3;
  localparam logic [STEP_W-1:0] STEP_TOT_LO = 3'd4;
  localparam logic [STEP_W-1:0] STEP_IDX_HI = 3'd5;
  localparam logic [STEP_W-1:0] STEP_IDX_LO = 3'd6;
  localparam logic [STEP_W-1:0] STEP_DATA   = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIVIDE,
    ST_EMIT
  } msplit_state_t;

  typedef struct packed {
    logic accept;     // latch the input byte and length
    logic prep;       // set up a new message
    logic div_start;  // start the chunk count division
    logic load_total; // take the chunk count from the divider
    logic step_init;  // load the first output step for this byte
    logic emit;       // load one byte into the output register
  } msplit_cmd_t;

  typedef struct packed {
    logic first;      // next byte opens a message
    logic split_now;  // the message being set up needs splitting
    logic div_done;   // divider result is ready
    logic out_free;   // output register can take a byte this cycle
    logic at_data;    // current step is the payload byte
  } msplit_status_t;

endpackage
`default_nettype wire

@@ design/msplit_intf.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msplit_intf: channel interfaces of the message splitter
// Input byte channel, output packet byte channel and the configuration
// write channel, each with valid/ready and a source and a sink view.
// ----------------------------------------------------------------------------
interface msplit_msg_if;
  logic                          valid;
  logic                          ready;
  logic [msplit_pkg::BYTE_W-1:0] data_byte;
  logic [msplit_pkg::LEN_W-1:0]  msg_length;

  modport source (output valid, output data_byte, output msg_length, input ready);
  modport sink   (input valid, input data_byte, input msg_length, output ready);
endinterface

interface msplit_pkt_if;
  logic                          valid;
  logic                          ready;
  logic [msplit_pkg::BYTE_W-1:0] out_byte;
  logic                          packet_start;
  logic                          packet_end;
  logic                          run_last;

  modport source (output valid, output out_byte, output packet_start,
                  output packet_end, output run_last, input ready);
  modport sink   (input valid, input out_byte, input packet_start,
                  input packet_end, input run_last, output ready);
endinterface

interface msplit_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [msplit_pkg::CFG_IDX_W-1:0]  index;
  logic [msplit_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ design/msplit_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msplit_divider: iterative chunk count divider
// Restoring division, one quotient bit per cycle, rounding the quotient up
// when a remainder is left.
// ----------------------------------------------------------------------------
module msplit_divider (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [msplit_pkg::LEN_W-1:0] dividend,
  input  wire logic [msplit_pkg::LEN_W-1:0] divisor,
  output logic                              done,
  output logic      [msplit_pkg::LEN_W-1:0] quotient_ceil
);
  import msplit_pkg::*;

  logic [DIV_CNT_W-1:0] count;
  logic [LEN_W-1:0]     rem;
  logic [LEN_W-1:0]     dq;
  logic [LEN_W-1:0]     dvs;
  logic [LEN_W:0]       shifted;
  logic [LEN_W:0]       diff;
  logic                 ge;

  assign shifted = {rem, dq[LEN_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (count == DIV_CNT_W'(1));
      if (start) begin
        count <= DIV_CNT_W'(LEN_W);
      end else if (count != '0) begin
        count <= count - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
      dvs <= divisor;
    end else if (count != '0) begin
      rem <= ge ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
      dq  <= {dq[LEN_W-2:0], ge};
    end
  end

  assign quotient_ceil = dq + {{(LEN_W-1){1'b0}}, (rem != '0)};

endmodule
`default_nettype wire

@@ design/msplit_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msplit_datapath: message splitter datapath
// Configuration registers, message and chunk counters, header byte
// selection and the output register.
// ----------------------------------------------------------------------------
module msplit_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire msplit_pkg::msplit_cmd_t           cmd,
  output msplit_pkg::msplit_status_t             status,
  input  wire logic [msplit_pkg::BYTE_W-1:0]     data_byte,
  input  wire logic [msplit_pkg::LEN_W-1:0]      msg_length,
  input  wire logic                              cfg_valid,
  input  wire logic [msplit_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [msplit_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                              pkt_ready,
  output logic                                   pkt_valid,
  output logic      [msplit_pkg::BYTE_W-1:0]     out_byte,
  output logic                                   packet_start,
  output logic                                   packet_end,
  output logic                                   run_last
);
  import msplit_pkg::*;

  logic [LEN_W-1:0]  chunk_limit;
  logic [BYTE_W-1:0] original_type_code;
  logic [BYTE_W-1:0] split_type_code;

  logic [BYTE_W-1:0] byte_reg;
  logic [LEN_W-1:0]  len_reg;
  logic [LEN_W-1:0]  msg_total;
  logic [LEN_W-1:0]  chunk_room;
  logic [LEN_W-1:0]  msg_position;
  logic [LEN_W-1:0]  chunk_position;
  logic [LEN_W-1:0]  chunk_index;
  logic [LEN_W-1:0]  chunk_total;
  logic [LEN_W-1:0]  split_sequence;
  logic              splitting;
  logic [STEP_W-1:0] step;

  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  room_now;
  logic              split_now;
  logic              split_sel;
  logic              cp_zero_sel;
  logic [STEP_W-1:0] step_start;
  logic              last_of_msg;
  logic              chunk_end;
  logic [BYTE_W-1:0] byte_sel;
  logic              start_sel;
  logic              end_sel;
  logic              div_done;
  logic [LEN_W-1:0]  div_q;

  // A zero length counts as one byte.
  assign len_eff   = (len_reg == '0) ? LEN_W'(1) : len_reg;
  assign split_now = ({1'b0, len_eff} + (LEN_W+1)'(1)) > {1'b0, chunk_limit};
  assign room_now  = (chunk_limit > LEN_W'(HDR_BYTES)) ?
                     chunk_limit - LEN_W'(HDR_BYTES) : LEN_W'(1);

  msplit_divider u_divider (
    .clk           (clk),
    .rst           (rst),
    .start         (cmd.div_start),
    .dividend      (len_eff),
    .divisor       (room_now),
    .done          (div_done),
    .quotient_ceil (div_q)
  );

  // While a message is being set up the registers do not yet hold its mode.
  assign split_sel   = cmd.prep ? split_now : splitting;
  assign cp_zero_sel = cmd.prep || (chunk_position == '0);

  always_comb begin
    if (split_sel) begin
      step_start = cp_zero_sel ? STEP_TYPE : STEP_DATA;
    end else begin
      step_start = (msg_position == '0) ? STEP_IDX_LO : STEP_DATA;
    end
  end

  assign last_of_msg = ({1'b0, msg_position} + (LEN_W+1)'(1)) >= {1'b0, msg_total};
  assign chunk_end   = last_of_msg ||
                       (({1'b0, chunk_position} + (LEN_W+1)'(1)) >= {1'b0, chunk_room});

  always_comb begin
    unique case (step)
      STEP_TYPE:   byte_sel = split_type_code;
      STEP_SEQ_HI: byte_sel = split_sequence[LEN_W-1:BYTE_W];
      STEP_SEQ_LO: byte_sel = split_sequence[BYTE_W-1:0];
      STEP_TOT_HI: byte_sel = chunk_total[LEN_W-1:BYTE_W];
      STEP_TOT_LO: byte_sel = chunk_total[BYTE_W-1:0];
      STEP_IDX_HI: byte_sel = chunk_index[LEN_W-1:BYTE_W];
      STEP_IDX_LO: byte_sel = splitting ? chunk_index[BYTE_W-1:0] : original_type_code;
      STEP_DATA:   byte_sel = byte_reg;
      default:     byte_sel = byte_reg;
    endcase
  end

  assign start_sel = (step == STEP_TYPE) || ((step == STEP_IDX_LO) && !splitting);
  assign end_sel   = (step == STEP_DATA) && (splitting ? chunk_end : last_of_msg);

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_limit        <= RST_CHUNK_LIMIT;
      original_type_code <= RST_ORIGINAL_TYPE;
      split_type_code    <= RST_SPLIT_TYPE;
      msg_total          <= '0;
      chunk_room         <= '0;
      msg_position       <= '0;
      chunk_position     <= '0;
      chunk_index        <= '0;
      chunk_total        <= '0;
      split_sequence     <= '0;
      splitting          <= 1'b0;
      step               <= STEP_TYPE;
      pkt_valid          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_CHUNK_LIMIT:   chunk_limit        <= cfg_data[LEN_W-1:0];
          CFG_ORIGINAL_TYPE: original_type_code <= cfg_data[BYTE_W-1:0];
          CFG_SPLIT_TYPE:    split_type_code    <= cfg_data[BYTE_W-1:0];
          default: ;
        endcase
      end

      if (cmd.prep) begin
        msg_total      <= len_eff;
        chunk_room     <= room_now;
        chunk_position <= '0;
        chunk_index    <= '0;
        splitting      <= split_now;
      end

      if (cmd.load_total) begin
        chunk_total <= div_q;
      end

      if (cmd.step_init) begin
        step <= step_start;
      end

      if (cmd.emit) begin
        if (step == STEP_DATA) begin
          if (splitting) begin
            if (chunk_end) begin
              chunk_position <= '0;
              chunk_index    <= chunk_index + LEN_W'(1);
            end else begin
              chunk_position <= chunk_position + LEN_W'(1);
            end
          end
          if (last_of_msg) begin
            if (splitting) begin
              split_sequence <= split_sequence + LEN_W'(1);
            end
            msg_position   <= '0;
            chunk_position <= '0;
            chunk_index    <= '0;
            splitting      <= 1'b0;
          end else begin
            msg_position <= msg_position + LEN_W'(1);
          end
        end else begin
          step <= step + STEP_W'(1);
        end
      end

      if (cmd.emit) begin
        pkt_valid <= 1'b1;
      end else if (pkt_ready) begin
        pkt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_reg <= data_byte;
      len_reg  <= msg_length;
    end
    if (cmd.emit) begin
      out_byte     <= byte_sel;
      packet_start <= start_sel;
      packet_end   <= end_sel;
      run_last     <= (step == STEP_DATA);
    end
  end

  assign status.first     = (msg_position == '0);
  assign status.split_now = split_now;
  assign status.div_done  = div_done;
  assign status.out_free  = !pkt_valid || pkt_ready;
  assign status.at_data   = (step == STEP_DATA);

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!pkt_valid || pkt_ready))
    else $error("byte loaded over an untaken output transaction");

  a_chunk_position_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && (step == STEP_DATA) && splitting) |-> (chunk_position < chunk_room))
    else $error("chunk position ran past the chunk payload size");

  a_msg_position_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && (step == STEP_DATA)) |-> (msg_position < msg_total))
    else $error("message position ran past the message length");

endmodule
`default_nettype wire

@@ design/msplit_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msplit_ctrl: message splitter controller
// Sequences input acceptance, message set-up, the chunk count division and
// the output of header and payload bytes.
// ----------------------------------------------------------------------------
module msplit_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       msg_valid,
  output logic                            msg_ready,
  input  wire msplit_pkg::msplit_status_t status,
  output msplit_pkg::msplit_cmd_t         cmd
);
  import msplit_pkg::*;

  msplit_state_t state;
  msplit_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (msg_valid) begin
          state_next = status.first ? ST_PREP : ST_EMIT;
        end
      end
      ST_PREP: begin
        state_next = status.split_now ? ST_DIVIDE : ST_EMIT;
      end
      ST_DIVIDE: begin
        if (status.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free && status.at_data) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    msg_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        msg_ready     = 1'b1;
        cmd.accept    = msg_valid;
        cmd.step_init = msg_valid && !status.first;
      end
      ST_PREP: begin
        cmd.prep      = 1'b1;
        cmd.div_start = status.split_now;
        cmd.step_init = !status.split_now;
      end
      ST_DIVIDE: begin
        cmd.load_total = status.div_done;
        cmd.step_init  = status.div_done;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ design/message_auto_splitter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// message_auto_splitter: packet segmentation with chunk headers
// Takes message bytes one transaction at a time and sends them on as one
// unsplit packet or as a run of chunks, each behind a seven-byte header.
// ----------------------------------------------------------------------------
//
//  Channel  Role    Payload                                      Width
//  -------  ------  -------------------------------------------  -----
//  msg      sink    data_byte, msg_length                         8+16
//  pkt      source  out_byte, packet_start, packet_end, run_last  8+1+1+1
//  cfg      sink    index (0 limit, 1 original, 2 split), data    2+16
//
// A byte in the middle of a chunk is accepted in the idle state and then
// loaded into the output register in the emit state. A byte that opens a
// chunk first sends the seven header bytes, one per cycle while the output
// is free. The first byte of a message also passes the set-up state and,
// when split, waits on the iterative chunk count divider (sixteen quotient
// bits, then the done flag). Reset (synchronous, active high) returns the
// counters, configuration registers, controller state and output valid
// flag to their initial values. A stall on the output side holds the
// controller in its emit state, one byte waiting in the output register.
//
// The block accepts a new input transaction while the last result of the
// previous one still waits in the output register. Message length and
// chunk limit are sampled on the first byte of each message; the type codes
// are read as each header byte is produced. The configuration channel is
// always ready, and writes to an index outside the register list are
// dropped.
// ----------------------------------------------------------------------------
module message_auto_splitter (
  input  wire logic clk,
  input  wire logic rst,
  msplit_msg_if.sink   msg,
  msplit_pkt_if.source pkt,
  msplit_cfg_if.sink   cfg
);
  import msplit_pkg::*;

  msplit_cmd_t    cmd;
  msplit_status_t status;

  // Configuration writes never wait.
  assign cfg.ready = 1'b1;

  msplit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg.valid),
    .msg_ready (msg.ready),
    .status    (status),
    .cmd       (cmd)
  );

  msplit_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .data_byte    (msg.data_byte),
    .msg_length   (msg.msg_length),
    .cfg_valid    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .pkt_ready    (pkt.ready),
    .pkt_valid    (pkt.valid),
    .out_byte     (pkt.out_byte),
    .packet_start (pkt.packet_start),
    .packet_end   (pkt.packet_end),
    .run_last     (pkt.run_last)
  );

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for message_auto_splitter
// Drives message bytes and register writes through the channel interfaces,
// predicts every packet byte with its own model of the splitter, and checks
// each output transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import msplit_pkg::*;

  // The run is cut short here. About 200 message bytes are sent, each
  // causing at most eight packet bytes.
  localparam int unsigned CYCLE_LIMIT = 300_000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned DIRECTED_ROWS = 34;

  // Index that selects no register; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // One row of the directed script. For item rows, exp_n and exp_first give
  // the number of packet bytes and the leading byte where they are obvious;
  // a zero exp_n leaves the row to the predictor alone.
  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [15:0]           value;
    logic [LEN_W-1:0]      length;
    int unsigned           exp_n;
    logic [BYTE_W-1:0]     exp_first;
  } stim_row_t;

  // One predicted output transaction.
  typedef struct {
    logic [BYTE_W-1:0] value;
    logic              first;
    logic              last;
    logic              run_end;
  } pkt_beat_t;

  logic clk;
  logic rst;

  msplit_msg_if msg_ch ();
  msplit_pkt_if pkt_ch ();
  msplit_cfg_if cfg_ch ();

  message_auto_splitter DUT (
    .clk (clk),
    .rst (rst),
    .msg (msg_ch),
    .pkt (pkt_ch),
    .cfg (cfg_ch)
  );

  // Packet bytes predicted but not yet seen on the output channel.
  pkt_beat_t expected_pkt_bytes[$];
  int unsigned mismatch_count = 0;

  // When set, neither side inserts gaps or stalls.
  bit steady = 1'b0;

  // Register copies held by the predictor.
  int unsigned limit_reg     = RST_CHUNK_LIMIT;
  int unsigned orig_type_reg = RST_ORIGINAL_TYPE;
  int unsigned split_type_reg = RST_SPLIT_TYPE;

  // Predictor state. Length and payload room are latched on the first byte
  // of each message, so changes to the limit only bite on the next message.
  int unsigned msg_pos      = 0;
  int unsigned chunk_pos    = 0;
  int unsigned chunk_idx    = 0;
  int unsigned chunk_tally  = 0;
  int unsigned split_seq    = 0;
  bit          in_split     = 1'b0;
  int unsigned msg_len      = 0;
  int unsigned payload_room = 0;

  // The directed script: reset values first, then the field extremes, the
  // boundary where length plus one equals the limit, the tiny limits that
  // leave one payload byte per chunk, a zero length, lengths that change in
  // the middle of a message, and register writes in the middle of a split
  // message, which must leave that message's chunking alone.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_ITEM, CFG_NO_REG,        16'h0000, 16'd1,     2, 8'h01},
    '{ROW_ITEM, CFG_NO_REG,        16'h00FF, 16'd0,     2, 8'h01},
    '{ROW_ITEM, CFG_NO_REG,        16'h005A, 16'd3,     2, 8'h01},
    '{ROW_ITEM, CFG_NO_REG,        16'h00A5, 16'd3,     1, 8'hA5},
    '{ROW_ITEM, CFG_NO_REG,        16'h003C, 16'hFFFF,  1, 8'h3C},
    '{ROW_REG,  CFG_CHUNK_LIMIT,   16'd8,    16'd0,     0, 8'h00},
    '{ROW_REG,  CFG_SPLIT_TYPE,    16'hFFFF, 16'd0,     0, 8'h00},
    '{ROW_ITEM, CFG_NO_REG,        16'h0011, 16'd2,     2, 8'h01},
    '{ROW_ITEM, CFG_NO_REG,        16'h0022, 16'd2,     1, 8'h22},
    '{ROW_REG,  CFG_ORIGINAL_TYPE, 16'h1200, 16'd0,     0, 8'h00},
    '{ROW_REG,  CFG_CHUNK_LIMIT,   16'd3,    16'd0,     0, 8'h00},
    '{ROW_ITEM, CFG_NO_REG,        16'h0080, 16'd2,     2, 8'h00},
    '{ROW_ITEM, CFG_NO_REG,        16'h007F, 16'd2,     1, 8'h7F},
    '{ROW_ITEM, CFG_NO_REG,        16'h0001, 16'd3,     8, 8'hFF},
    '{ROW_ITEM, CFG_NO_REG,        16'h0002, 16'hFFFF,  8, 8'hFF},
    '{ROW_ITEM, CFG_NO_REG,        16'h0003, 16'd0,     8, 8'hFF},
    '{ROW_REG,  CFG_CHUNK_LIMIT,   16'd0,    16'd0,     0, 8'h00},
    '{ROW_ITEM, CFG_NO_REG,        16'h00C3, 16'd1,     8, 8'hFF},
    '{ROW_REG,  CFG_CHUNK_LIMIT,   16'd9,    16'd0,     0, 8'h00},
    '{ROW_ITEM, CFG_NO_REG,        16'h0010, 16'd9,     8, 8'hFF},
    '{ROW_ITEM, CFG_NO_REG,        16'h0020, 16'd9,     0, 8'h00},
    '{ROW_ITEM, CFG_NO_REG,        16'h0040, 16'd9,     8, 8'hFF},
    '{ROW_ITEM, CFG_NO_REG,        16'h0008, 16'd9,     0, 8'h00},
    '{ROW_REG,  CFG_CHUNK_LIMIT,   16'hFFFF, 16'd0,     0, 8'h00},
    '{ROW_REG,  CFG_SPLIT_TYPE,    16'h0000, 16'd0,     0, 8'h00},
    '{ROW_REG,  CFG_ORIGINAL_TYPE, 16'h00FF, 16'd0,     0, 8'h00},
    '{ROW_ITEM, CFG_NO_REG,        16'h0004, 16'd9,     8, 8'h00},
    '{ROW_ITEM, CFG_NO_REG,        16'h00F7, 16'd9,     0, 8'h00},
    '{ROW_ITEM, CFG_NO_REG,        16'h00EF, 16'd9,     8, 8'h00},
    '{ROW_ITEM, CFG_NO_REG,        16'h00DF, 16'd9,     0, 8'h00},
    '{ROW_ITEM, CFG_NO_REG,        16'h00BF, 16'd9,     8, 8'h00},
    '{ROW_ITEM, CFG_NO_REG,        16'h0055, 16'd1,     2, 8'hFF},
    '{ROW_REG,  CFG_NO_REG,        16'hFFFF, 16'd0,     0, 8'h00},
    '{ROW_ITEM, CFG_NO_REG,        16'h00AA, 16'd1,     2, 8'hFF}
  };

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic pkt_beat_t beat(input int unsigned v, input bit st, input bit en);
    pkt_beat_t b;
    b.value   = 8'(v);
    b.first   = st;
    b.last    = en;
    b.run_end = 1'b0;
    return b;
  endfunction

  // Mirrors a register write in the predictor. The type registers keep only
  // their low byte; an unknown index changes nothing.
  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    case (idx)
      CFG_CHUNK_LIMIT:   limit_reg = value;
      CFG_ORIGINAL_TYPE: orig_type_reg = value[7:0];
      CFG_SPLIT_TYPE:    split_type_reg = value[7:0];
      default: ;
    endcase
  endtask

  // Works out the packet bytes that one accepted message byte causes and
  // queues them. Returns their number and the leading byte.
  task automatic predict_packet_bytes(input logic [BYTE_W-1:0] d,
                                      input logic [LEN_W-1:0] len_in,
                                      output int unsigned n,
                                      output logic [BYTE_W-1:0] head);
    pkt_beat_t run[$];
    int unsigned len;
    bit last_of_msg;
    bit chunk_done;
    if (msg_pos == 0) begin
      // A zero length counts as one byte.
      len = (len_in == 0) ? 1 : len_in;
      msg_len   = len;
      chunk_pos = 0;
      chunk_idx = 0;
      if (len + 1 > limit_reg) begin
        in_split = 1'b1;
        // Limits at or below the header size still leave one payload byte.
        payload_room = (limit_reg > HDR_BYTES) ? limit_reg - HDR_BYTES : 1;
        chunk_tally  = ((len + payload_room - 1) / payload_room) & 16'hFFFF;
      end else begin
        in_split     = 1'b0;
        payload_room = 0;
        chunk_tally  = 0;
      end
    end

    last_of_msg = (msg_pos + 1) >= msg_len;

    if (!in_split) begin
      if (msg_pos == 0)
        run.insert(run.size(), beat(orig_type_reg, 1'b1, 1'b0));
      run.insert(run.size(), beat(d, 1'b0, last_of_msg));
    end else begin
      if (chunk_pos == 0) begin
        // Header bytes never close a chunk, as payload always follows.
        run.insert(run.size(), beat(split_type_reg, 1'b1, 1'b0));
        run.insert(run.size(), beat(split_seq >> 8, 1'b0, 1'b0));
        run.insert(run.size(), beat(split_seq, 1'b0, 1'b0));
        run.insert(run.size(), beat(chunk_tally >> 8, 1'b0, 1'b0));
        run.insert(run.size(), beat(chunk_tally, 1'b0, 1'b0));
        run.insert(run.size(), beat(chunk_idx >> 8, 1'b0, 1'b0));
        run.insert(run.size(), beat(chunk_idx, 1'b0, 1'b0));
      end
      chunk_done = last_of_msg || (chunk_pos + 1) >= payload_room;
      run.insert(run.size(), beat(d, 1'b0, chunk_done));
      if (chunk_done) begin
        chunk_pos = 0;
        chunk_idx = (chunk_idx + 1) & 16'hFFFF;
      end else begin
        chunk_pos = (chunk_pos + 1) & 16'hFFFF;
      end
    end

    if (last_of_msg) begin
      if (in_split)
        split_seq = (split_seq + 1) & 16'hFFFF;
      msg_pos   = 0;
      chunk_pos = 0;
      chunk_idx = 0;
      in_split  = 1'b0;
    end else begin
      msg_pos = (msg_pos + 1) & 16'hFFFF;
    end

    run[run.size() - 1].run_end = 1'b1;
    n    = run.size();
    head = run[0].value;
    foreach (run[k])
      expected_pkt_bytes.insert(expected_pkt_bytes.size(), run[k]);
  endtask

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------

  // Offers one message byte, after a random gap, and waits for the
  // transaction. Valid is left high so that a following byte with no gap
  // keeps the channel busy without a dropout.
  task automatic send_msg_byte(input logic [BYTE_W-1:0] d, input logic [LEN_W-1:0] len,
                               output int unsigned n, output logic [BYTE_W-1:0] head);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      msg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_ch.valid      <= 1'b1;
    msg_ch.data_byte  <= d;
    msg_ch.msg_length <= len;
    do @(posedge clk); while (!msg_ch.ready);
    predict_packet_bytes(d, len, n, head);
  endtask

  // Random byte of a well-formed message, with some noise: now and then a
  // zero length opens a message, and later bytes sometimes carry a length
  // that differs from the one latched, which the block must ignore.
  task automatic send_random_byte(input int unsigned max_len);
    logic [LEN_W-1:0] len;
    int unsigned n;
    logic [BYTE_W-1:0] head;
    if (msg_pos == 0)
      len = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, max_len));
    else if ($urandom_range(0, 3) == 0)
      len = 16'($urandom);
    else
      len = 16'(msg_len);
    send_msg_byte(8'($urandom), len, n, head);
  endtask

  // Stops offering bytes and waits until every predicted byte has arrived.
  task automatic drain_results();
    msg_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_pkt_bytes.size() != 0);
  endtask

  // One register write. Valid stays high so that back-to-back writes need
  // no dropout; the caller lowers it after the last write of a batch.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_register(idx, value);
  endtask

  task automatic set_registers(input logic [15:0] limit, input logic [7:0] orig,
                               input logic [7:0] split);
    drain_results();
    write_register(CFG_CHUNK_LIMIT, limit);
    write_register(CFG_ORIGINAL_TYPE, {8'($urandom), orig});
    write_register(CFG_SPLIT_TYPE, {8'($urandom), split});
    cfg_ch.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Output side: random back-pressure and the per-field comparison
  // --------------------------------------------------------------------------
  initial begin : packet_sink
    pkt_beat_t want;
    int unsigned stall_left;
    stall_left = 0;
    pkt_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      // Values sampled here are those the block saw at this edge.
      if (!rst && pkt_ch.valid && pkt_ch.ready) begin
        if (expected_pkt_bytes.size() == 0) begin
          report_mismatch($sformatf("packet byte %02h with nothing expected",
                                    pkt_ch.out_byte));
        end else begin
          want = expected_pkt_bytes.pop_front();
          if (pkt_ch.out_byte !== want.value)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      pkt_ch.out_byte, want.value));
          if (pkt_ch.packet_start !== want.first)
            report_mismatch($sformatf("packet_start %b, expected %b",
                                      pkt_ch.packet_start, want.first));
          if (pkt_ch.packet_end !== want.last)
            report_mismatch($sformatf("packet_end %b, expected %b",
                                      pkt_ch.packet_end, want.last));
          if (pkt_ch.run_last !== want.run_end)
            report_mismatch($sformatf("run_last %b, expected %b",
                                      pkt_ch.run_last, want.run_end));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        pkt_ch.ready <= 1'b0;
      end else begin
        pkt_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned n;
    logic [BYTE_W-1:0] head;
    int unsigned max_len;

    rst               <= 1'b1;
    msg_ch.valid      <= 1'b0;
    msg_ch.data_byte  <= '0;
    msg_ch.msg_length <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= CFG_CHUNK_LIMIT;
    cfg_ch.data       <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed script. Register rows come in batches; each batch waits for
    // the output to run dry first, so writes only land while the block is
    // idle, even where that falls in the middle of a message.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_REG) begin
        if (i == 0 || directed_rows[i - 1].kind != ROW_REG)
          drain_results();
        write_register(directed_rows[i].idx, directed_rows[i].value);
        if (i + 1 == DIRECTED_ROWS || directed_rows[i + 1].kind != ROW_REG)
          cfg_ch.valid <= 1'b0;
      end else begin
        send_msg_byte(directed_rows[i].value[7:0], directed_rows[i].length, n, head);
        if (directed_rows[i].exp_n != 0 &&
            (n != directed_rows[i].exp_n || head != directed_rows[i].exp_first))
          report_mismatch($sformatf("script row %0d: %0d bytes led by %02h, table says %0d by %02h",
                                    i, n, head, directed_rows[i].exp_n,
                                    directed_rows[i].exp_first));
      end
    end

    // Random part in four settings: a tiny limit, where each byte of a split
    // message opens a chunk; two small limits, so most messages split into
    // a few chunks; and a moderate one, mixing split and unsplit messages.
    // The second never idles. A setting may change in the middle of a message.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          set_registers(16'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
          max_len = 12;
        end
        1: begin
          set_registers(16'($urandom_range(8, 20)), 8'($urandom), 8'($urandom));
          max_len = 40;
        end
        2: begin
          set_registers(16'($urandom_range(8, 48)), 8'($urandom), 8'($urandom));
          max_len = 40;
        end
        default: begin
          set_registers(16'($urandom_range(9, 60)), 8'($urandom), 8'($urandom));
          max_len = 40;
        end
      endcase
      steady = (p == 1);
      for (int k = 0; k < 40; k++) begin
        // Once, halfway through, hold off until the output has caught up.
        if (p == 2 && k == 20)
          drain_results();
        send_random_byte(max_len);
      end
    end
    steady = 1'b0;

    // Close any message left open so that the last one starts cleanly.
    while (msg_pos != 0)
      send_random_byte(40);

    // The opening bytes of the largest message at the largest limit: one
    // byte too long to fit, so it splits into a full chunk and a short one.
    // The message is left open, as only its header and first bytes matter.
    set_registers(16'hFFFF, 8'($urandom), 8'($urandom));
    for (int k = 0; k < 4; k++)
      send_msg_byte(8'($urandom), 16'hFFFF, n, head);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
